@@ rtl/smftep_pkg.sv @@
// ----------------------------------------------------------------------------
// smftep_pkg: shared types, codes and helpers of the MIDI file track parser
// Holds the parser phase type, the result item layout, the status and
// error codes and small functions that build result items.
// ----------------------------------------------------------------------------
package smftep_pkg;

   localparam int MAX_SYSEX_BYTES_DEF = 1024;
   localparam int TICK_WIDTH_DEF      = 32;
   localparam int RSP_QUEUE_DEPTH     = 8;

   localparam int VLQ_WIDTH  = 28;
   localparam int TEMPO_WIDTH = 24;
   localparam int OUT_TICK_WIDTH = 32;

   typedef enum logic [2:0] {
      PH_DELTA     = 3'd0,
      PH_STATUS    = 3'd1,
      PH_CHAN      = 3'd2,
      PH_META_TYPE = 3'd3,
      PH_META_LEN  = 3'd4,
      PH_META_DATA = 3'd5,
      PH_SYX_LEN   = 3'd6,
      PH_SYX_DATA  = 3'd7
   } phase_type;

   localparam logic [1:0] KIND_EVENT = 2'd0;
   localparam logic [1:0] KIND_TEMPO = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [2:0] ERR_LONG_DELTA   = 3'd0;
   localparam logic [2:0] ERR_NO_RUNNING   = 3'd1;
   localparam logic [2:0] ERR_BAD_STATUS   = 3'd2;
   localparam logic [2:0] ERR_BAD_LENGTH   = 3'd3;
   localparam logic [2:0] ERR_SYSEX_LARGE  = 3'd4;
   localparam logic [2:0] ERR_TRUNCATED    = 3'd5;

   localparam logic [7:0] ST_SYSEX     = 8'hF0;
   localparam logic [7:0] ST_ESCAPE    = 8'hF7;
   localparam logic [7:0] ST_META      = 8'hFF;
   localparam logic [7:0] ST_SYSTEM    = 8'hF0;
   localparam logic [3:0] HI_PROGRAM   = 4'hC;
   localparam logic [3:0] HI_PRESSURE  = 4'hD;
   localparam logic [7:0] META_TEMPO   = 8'h51;

   typedef struct packed {
      logic [1:0]                kind;
      logic [7:0]                byte_value;
      logic [OUT_TICK_WIDTH-1:0] event_tick;
      logic                      first_of_event;
      logic [TEMPO_WIDTH-1:0]    quarter_usec;
      logic [2:0]                error_code;
      logic                      is_last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } parse_out_type;

   // data bytes that follow a channel status byte
   function automatic logic [1:0] data_count(input logic [7:0] status);
      logic [3:0] hi;
      hi = status[7:4];
      if (hi == HI_PROGRAM || hi == HI_PRESSURE) begin
         return 2'd1;
      end
      return 2'd2;
   endfunction

   function automatic rsp_item_type event_item(input logic [7:0] value,
                                               input logic first,
                                               input logic [31:0] tick);
      rsp_item_type r;
      r = '0;
      r.kind = KIND_EVENT;
      r.byte_value = value;
      r.event_tick = tick;
      r.first_of_event = first;
      return r;
   endfunction

   function automatic rsp_item_type tempo_item(input logic [23:0] tempo,
                                               input logic [31:0] tick);
      rsp_item_type r;
      r = '0;
      r.kind = KIND_TEMPO;
      r.event_tick = tick;
      r.quarter_usec = tempo;
      return r;
   endfunction

   function automatic rsp_item_type error_item(input logic [2:0] code);
      rsp_item_type r;
      r = '0;
      r.kind = KIND_ERROR;
      r.error_code = code;
      return r;
   endfunction

endpackage

@@ rtl/smftep_if.sv @@
// ----------------------------------------------------------------------------
// smftep_if: channel interfaces of the MIDI file track parser
// Valid/ready channels for track bytes in and result items out.
// ----------------------------------------------------------------------------
interface smftep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_of_track;
   logic       last_of_track;

   modport source (output valid, output data_byte, output first_of_track,
                   output last_of_track, input ready);
   modport sink   (input valid, input data_byte, input first_of_track,
                   input last_of_track, output ready);
endinterface

interface smftep_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  byte_value;
   logic [31:0] event_tick;
   logic        first_of_event;
   logic [23:0] quarter_usec;
   logic [2:0]  error_code;
   logic        is_last;

   modport source (output valid, output kind, output byte_value, output event_tick,
                   output first_of_event, output quarter_usec, output error_code,
                   output is_last, input ready);
   modport sink   (input valid, input kind, input byte_value, input event_tick,
                   input first_of_event, input quarter_usec, input error_code,
                   input is_last, output ready);
endinterface

@@ rtl/smftep_parser.sv @@
// ----------------------------------------------------------------------------
// smftep_parser: track byte decoder
// Holds the parser state and decodes one registered track byte per cycle
// into zero, one or two result items.
// ----------------------------------------------------------------------------
module smftep_parser #(
   parameter int MAX_SYSEX_BYTES = smftep_pkg::MAX_SYSEX_BYTES_DEF,
   parameter int TICK_WIDTH      = smftep_pkg::TICK_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      byte_valid,
   input  logic [7:0]                data_byte,
   input  logic                      first_of_track,
   input  logic                      last_of_track,
   output smftep_pkg::parse_out_type parse_out
);

   localparam int VW  = smftep_pkg::VLQ_WIDTH;
   localparam int SCW = $clog2(MAX_SYSEX_BYTES + 1);
   localparam int SW  = TICK_WIDTH + 1;

   smftep_pkg::phase_type    phase_ff, phase_in, phase_e;
   logic [VW-1:0]            vlq_value_ff, vlq_value_in, vlq_value_e;
   logic [2:0]               vlq_bytes_ff, vlq_bytes_in, vlq_bytes_e;
   logic [TICK_WIDTH-1:0]    track_tick_ff, track_tick_in, track_tick_e;
   logic [7:0]               running_status_ff, running_status_in, running_status_e;
   logic [7:0]               current_status_ff, current_status_in, current_status_e;
   logic [1:0]               data_left_ff, data_left_in, data_left_e;
   logic [7:0]               meta_type_ff, meta_type_in, meta_type_e;
   logic [VW-1:0]            length_left_ff, length_left_in, length_left_e;
   logic [SCW-1:0]           sysex_count_ff, sysex_count_in, sysex_count_e;
   logic [23:0]              tempo_acc_ff, tempo_acc_in, tempo_acc_e;
   logic                     tempo_valid_ff, tempo_valid_in, tempo_valid_e;
   logic                     error_hold_ff, error_hold_in, error_hold_e;

   logic [VW-1:0]            vlq_next;
   logic [2:0]               vlq_bytes_next;
   logic                     vlq_more;
   logic                     vlq_long;
   logic [SW-1:0]            tick_sum;
   logic [31:0]              tick_out;
   logic [VW-1:0]            len_dec;
   logic                     fin;
   logic                     syx_open;
   logic [1:0]               dc;
   logic [1:0]               n;
   smftep_pkg::rsp_item_type r0, r1;

   always_comb begin
      // a new track clears everything before its first byte
      if (first_of_track) begin
         phase_e = smftep_pkg::PH_DELTA;
         vlq_value_e = '0;
         vlq_bytes_e = '0;
         track_tick_e = '0;
         running_status_e = '0;
         current_status_e = '0;
         data_left_e = '0;
         meta_type_e = '0;
         length_left_e = '0;
         sysex_count_e = '0;
         tempo_acc_e = '0;
         tempo_valid_e = 1'b0;
         error_hold_e = 1'b0;
      end else begin
         phase_e = phase_ff;
         vlq_value_e = vlq_value_ff;
         vlq_bytes_e = vlq_bytes_ff;
         track_tick_e = track_tick_ff;
         running_status_e = running_status_ff;
         current_status_e = current_status_ff;
         data_left_e = data_left_ff;
         meta_type_e = meta_type_ff;
         length_left_e = length_left_ff;
         sysex_count_e = sysex_count_ff;
         tempo_acc_e = tempo_acc_ff;
         tempo_valid_e = tempo_valid_ff;
         error_hold_e = error_hold_ff;
      end
   end

   assign vlq_next       = {vlq_value_e[VW-8:0], data_byte[6:0]};
   assign vlq_bytes_next = vlq_bytes_e + 3'd1;
   assign vlq_more       = data_byte[7];
   assign vlq_long       = data_byte[7] && (vlq_bytes_next >= 3'd4);
   assign tick_sum       = {1'b0, track_tick_e} + SW'(vlq_next);
   assign tick_out       = 32'(track_tick_e);
   assign len_dec        = length_left_e - VW'(1);
   assign fin            = (len_dec == '0);
   assign syx_open       = (current_status_e == smftep_pkg::ST_SYSEX)
                           && (data_byte != smftep_pkg::ST_ESCAPE);
   assign dc             = smftep_pkg::data_count(running_status_e);

   always_comb begin
      phase_in = phase_e;
      vlq_value_in = vlq_value_e;
      vlq_bytes_in = vlq_bytes_e;
      track_tick_in = track_tick_e;
      running_status_in = running_status_e;
      current_status_in = current_status_e;
      data_left_in = data_left_e;
      meta_type_in = meta_type_e;
      length_left_in = length_left_e;
      sysex_count_in = sysex_count_e;
      tempo_acc_in = tempo_acc_e;
      tempo_valid_in = tempo_valid_e;
      error_hold_in = error_hold_e;
      n = 2'd0;
      r0 = '0;
      r1 = '0;

      if (!error_hold_e) begin
         case (phase_e)
            smftep_pkg::PH_DELTA: begin
               if (vlq_long) begin
                  n = 2'd1;
                  r0 = smftep_pkg::error_item(smftep_pkg::ERR_LONG_DELTA);
                  error_hold_in = 1'b1;
               end else if (vlq_more) begin
                  vlq_value_in = vlq_next;
                  vlq_bytes_in = vlq_bytes_next;
               end else begin
                  // saturate the tick at its top value
                  track_tick_in = tick_sum[TICK_WIDTH] ? '1 : tick_sum[TICK_WIDTH-1:0];
                  vlq_value_in = '0;
                  vlq_bytes_in = '0;
                  phase_in = smftep_pkg::PH_STATUS;
               end
            end
            smftep_pkg::PH_STATUS: begin
               if (!data_byte[7]) begin
                  if (running_status_e == '0) begin
                     n = 2'd1;
                     r0 = smftep_pkg::error_item(smftep_pkg::ERR_NO_RUNNING);
                     error_hold_in = 1'b1;
                  end else begin
                     current_status_in = running_status_e;
                     n = 2'd2;
                     r0 = smftep_pkg::event_item(running_status_e, 1'b1, tick_out);
                     r1 = smftep_pkg::event_item(data_byte, 1'b0, tick_out);
                     data_left_in = dc - 2'd1;
                     phase_in = (dc != 2'd1) ? smftep_pkg::PH_CHAN : smftep_pkg::PH_DELTA;
                  end
               end else if (data_byte < smftep_pkg::ST_SYSTEM) begin
                  running_status_in = data_byte;
                  current_status_in = data_byte;
                  data_left_in = smftep_pkg::data_count(data_byte);
                  phase_in = smftep_pkg::PH_CHAN;
                  n = 2'd1;
                  r0 = smftep_pkg::event_item(data_byte, 1'b1, tick_out);
               end else if (data_byte == smftep_pkg::ST_META) begin
                  phase_in = smftep_pkg::PH_META_TYPE;
               end else if (data_byte == smftep_pkg::ST_SYSEX
                            || data_byte == smftep_pkg::ST_ESCAPE) begin
                  current_status_in = data_byte;
                  phase_in = smftep_pkg::PH_SYX_LEN;
               end else begin
                  n = 2'd1;
                  r0 = smftep_pkg::error_item(smftep_pkg::ERR_BAD_STATUS);
                  error_hold_in = 1'b1;
               end
            end
            smftep_pkg::PH_CHAN: begin
               n = 2'd1;
               r0 = smftep_pkg::event_item(data_byte, 1'b0, tick_out);
               data_left_in = data_left_e - 2'd1;
               if (data_left_e == 2'd1) begin
                  phase_in = smftep_pkg::PH_DELTA;
               end
            end
            smftep_pkg::PH_META_TYPE: begin
               meta_type_in = data_byte;
               phase_in = smftep_pkg::PH_META_LEN;
            end
            smftep_pkg::PH_META_LEN: begin
               if (vlq_long) begin
                  n = 2'd1;
                  r0 = smftep_pkg::error_item(smftep_pkg::ERR_BAD_LENGTH);
                  error_hold_in = 1'b1;
               end else if (vlq_more) begin
                  vlq_value_in = vlq_next;
                  vlq_bytes_in = vlq_bytes_next;
               end else begin
                  length_left_in = vlq_next;
                  tempo_valid_in = (meta_type_e == smftep_pkg::META_TEMPO)
                                   && (vlq_next == VW'(3));
                  tempo_acc_in = '0;
                  vlq_value_in = '0;
                  vlq_bytes_in = '0;
                  phase_in = (vlq_next != '0) ? smftep_pkg::PH_META_DATA
                                              : smftep_pkg::PH_DELTA;
               end
            end
            smftep_pkg::PH_META_DATA: begin
               if (tempo_valid_e) begin
                  tempo_acc_in = {tempo_acc_e[15:0], data_byte};
               end
               length_left_in = len_dec;
               if (fin) begin
                  phase_in = smftep_pkg::PH_DELTA;
                  if (tempo_valid_e) begin
                     n = 2'd1;
                     r0 = smftep_pkg::tempo_item({tempo_acc_e[15:0], data_byte},
                                                 tick_out);
                  end
               end
            end
            smftep_pkg::PH_SYX_LEN: begin
               if (vlq_long) begin
                  n = 2'd1;
                  r0 = smftep_pkg::error_item(smftep_pkg::ERR_BAD_LENGTH);
                  error_hold_in = 1'b1;
               end else if (vlq_more) begin
                  vlq_value_in = vlq_next;
                  vlq_bytes_in = vlq_bytes_next;
               end else begin
                  vlq_value_in = '0;
                  vlq_bytes_in = '0;
                  length_left_in = vlq_next;
                  if (current_status_e == smftep_pkg::ST_SYSEX) begin
                     if (vlq_next > VW'(MAX_SYSEX_BYTES - 1)) begin
                        n = 2'd1;
                        r0 = smftep_pkg::error_item(smftep_pkg::ERR_SYSEX_LARGE);
                        error_hold_in = 1'b1;
                     end else begin
                        // emit the leading F0, close an empty body at once
                        sysex_count_in = SCW'(1);
                        r0 = smftep_pkg::event_item(smftep_pkg::ST_SYSEX, 1'b1,
                                                    tick_out);
                        if (vlq_next == '0) begin
                           n = 2'd2;
                           r1 = smftep_pkg::event_item(smftep_pkg::ST_ESCAPE, 1'b0,
                                                       tick_out);
                           phase_in = smftep_pkg::PH_DELTA;
                        end else begin
                           n = 2'd1;
                           phase_in = smftep_pkg::PH_SYX_DATA;
                        end
                     end
                  end else if (vlq_next > VW'(MAX_SYSEX_BYTES)) begin
                     n = 2'd1;
                     r0 = smftep_pkg::error_item(smftep_pkg::ERR_SYSEX_LARGE);
                     error_hold_in = 1'b1;
                  end else begin
                     sysex_count_in = '0;
                     phase_in = (vlq_next != '0) ? smftep_pkg::PH_SYX_DATA
                                                 : smftep_pkg::PH_DELTA;
                  end
               end
            end
            smftep_pkg::PH_SYX_DATA: begin
               length_left_in = len_dec;
               if (fin && syx_open && (sysex_count_e >= SCW'(MAX_SYSEX_BYTES - 1))) begin
                  n = 2'd1;
                  r0 = smftep_pkg::error_item(smftep_pkg::ERR_SYSEX_LARGE);
                  error_hold_in = 1'b1;
               end else begin
                  r0 = smftep_pkg::event_item(data_byte, sysex_count_e == '0, tick_out);
                  sysex_count_in = sysex_count_e + SCW'(1);
                  n = 2'd1;
                  if (fin) begin
                     phase_in = smftep_pkg::PH_DELTA;
                     if (syx_open) begin
                        n = 2'd2;
                        r1 = smftep_pkg::event_item(smftep_pkg::ST_ESCAPE, 1'b0,
                                                    tick_out);
                     end
                  end
               end
            end
            default: begin
               phase_in = smftep_pkg::PH_DELTA;
            end
         endcase

         // track ends inside an event or a delta time
         if (last_of_track && !error_hold_in
             && (phase_in != smftep_pkg::PH_DELTA || vlq_bytes_in != '0)) begin
            n = 2'd1;
            r0 = smftep_pkg::error_item(smftep_pkg::ERR_TRUNCATED);
            r1 = '0;
            error_hold_in = 1'b1;
         end
      end

      if (n == 2'd1) begin
         r0.is_last = 1'b1;
      end
      if (n == 2'd2) begin
         r1.is_last = 1'b1;
      end
   end

   assign parse_out.count = byte_valid ? n : 2'd0;
   assign parse_out.item0 = r0;
   assign parse_out.item1 = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= smftep_pkg::PH_DELTA;
         vlq_value_ff <= '0;
         vlq_bytes_ff <= '0;
         track_tick_ff <= '0;
         running_status_ff <= '0;
         current_status_ff <= '0;
         data_left_ff <= '0;
         meta_type_ff <= '0;
         length_left_ff <= '0;
         sysex_count_ff <= '0;
         tempo_acc_ff <= '0;
         tempo_valid_ff <= 1'b0;
         error_hold_ff <= 1'b0;
      end else if (byte_valid) begin
         phase_ff <= phase_in;
         vlq_value_ff <= vlq_value_in;
         vlq_bytes_ff <= vlq_bytes_in;
         track_tick_ff <= track_tick_in;
         running_status_ff <= running_status_in;
         current_status_ff <= current_status_in;
         data_left_ff <= data_left_in;
         meta_type_ff <= meta_type_in;
         length_left_ff <= length_left_in;
         sysex_count_ff <= sysex_count_in;
         tempo_acc_ff <= tempo_acc_in;
         tempo_valid_ff <= tempo_valid_in;
         error_hold_ff <= error_hold_in;
      end
   end

endmodule

@@ rtl/smftep_rsp_queue.sv @@
// ----------------------------------------------------------------------------
// smftep_rsp_queue: result item queue
// Takes up to two result items per cycle and hands out one per cycle while popped.
// ----------------------------------------------------------------------------
module smftep_rsp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  smftep_pkg::parse_out_type push,
   input  logic                      pop,
   output logic                      head_valid,
   output smftep_pkg::rsp_item_type  head_item,
   output logic [$clog2(smftep_pkg::RSP_QUEUE_DEPTH+1)-1:0] fill
);

   localparam int Depth = smftep_pkg::RSP_QUEUE_DEPTH;
   localparam int PW    = $clog2(Depth);
   localparam int CW    = $clog2(Depth + 1);

   smftep_pkg::rsp_item_type slot_ff [Depth];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          pop_ok;

   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];
   assign fill       = count_ff;
   assign pop_ok     = pop && head_valid;

   assign wr_ptr_in = wr_ptr_ff + PW'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PW'(pop_ok);
   assign count_in  = count_ff + CW'(push.count) - CW'(pop_ok);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         slot_ff[wr_ptr_ff + PW'(1)] <= push.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/smf_track_event_parser.sv @@
// ----------------------------------------------------------------------------
// smf_track_event_parser: MIDI file track event parser
// Decodes track chunk body bytes into timed channel message bytes, SysEx
// bytes, tempo changes and error reports.
// ----------------------------------------------------------------------------
// A byte is accepted into an input register, decoded the next cycle and its
// zero, one or two result items are written into an 8-entry result queue.
// One byte is taken per cycle while the input is not stalled; the result port
// delivers one item per cycle while its ready is high, so bytes that cause two
// results (running-status pairs, SysEx open and close) take two transfers of
// output bandwidth, and the input stalls only when the queue cannot hold two
// more items beyond the byte in decode.
module smf_track_event_parser #(
   parameter int MAX_SYSEX_BYTES = smftep_pkg::MAX_SYSEX_BYTES_DEF,
   parameter int TICK_WIDTH      = smftep_pkg::TICK_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   smftep_req_if.sink  req_chan,
   smftep_rsp_if.source rsp_chan
);

   localparam int Depth = smftep_pkg::RSP_QUEUE_DEPTH;
   localparam int CW    = $clog2(Depth + 1);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_first_ff;
   logic       in_last_ff;
   logic       req_take;
   logic [CW-1:0] q_fill;
   logic [CW:0]   q_need;

   smftep_pkg::parse_out_type parse_out;
   smftep_pkg::rsp_item_type  head_item;
   logic                      head_valid;

   // hold back a byte unless its results and those in decode both fit
   assign q_need = {1'b0, q_fill} + (in_valid_ff ? (CW+1)'(2) : '0);
   assign req_chan.ready = (q_need <= (CW+1)'(Depth - 2));
   assign req_take = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.data_byte;
         in_first_ff <= req_chan.first_of_track;
         in_last_ff <= req_chan.last_of_track;
      end
   end

   smftep_parser #(
      .MAX_SYSEX_BYTES(MAX_SYSEX_BYTES),
      .TICK_WIDTH(TICK_WIDTH)
   ) u_parser (
      .clock(clock),
      .reset(reset),
      .byte_valid(in_valid_ff),
      .data_byte(in_byte_ff),
      .first_of_track(in_first_ff),
      .last_of_track(in_last_ff),
      .parse_out(parse_out)
   );

   smftep_rsp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(parse_out),
      .pop(rsp_chan.ready),
      .head_valid(head_valid),
      .head_item(head_item),
      .fill(q_fill)
   );

   assign rsp_chan.valid          = head_valid;
   assign rsp_chan.kind           = head_item.kind;
   assign rsp_chan.byte_value     = head_item.byte_value;
   assign rsp_chan.event_tick     = head_item.event_tick;
   assign rsp_chan.first_of_event = head_item.first_of_event;
   assign rsp_chan.quarter_usec   = head_item.quarter_usec;
   assign rsp_chan.error_code     = head_item.error_code;
   assign rsp_chan.is_last        = head_item.is_last;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_fill <= CW'(Depth))
      else $error("result queue overfilled");

   a_room_in_decode: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |-> q_fill <= CW'(Depth - 2))
      else $error("no room for results of byte in decode");

   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.kind == smftep_pkg::KIND_ERROR)
         |-> (rsp_chan.is_last && rsp_chan.event_tick == '0))
      else $error("error item not final or carries a tick");

   a_two_results_end: assert property (@(posedge clock) disable iff (reset)
      (parse_out.count == 2'd2) |-> (!parse_out.item0.is_last && parse_out.item1.is_last))
      else $error("is_last misplaced on a two-item byte");

endmodule

@@ bench/smf_track_event_parser_test.sv @@
// ---------------------------------------------------------------------------
// smf_track_event_parser_test: self-checking bench for the track event parser
// Sends directed and random track chunk bodies through the byte channel with
// random gaps and result back-pressure, predicts every result item from its
// own parser model and compares the result channel field by field.
// ---------------------------------------------------------------------------
module smf_track_event_parser_test;
   import smftep_pkg::*;

   localparam int ITEM_TARGET  = 1600;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int DRAIN_CYCLES = 20;
   localparam int REPORT_LIMIT = 40;
   localparam int SYSEX_LIMIT  = MAX_SYSEX_BYTES_DEF;
   localparam int TEMPO_LEN    = 3;
   localparam int SAT_EVENTS   = 18;

   localparam logic [7:0]  ST_NOTE_ON = 8'h90;
   localparam logic [7:0]  ST_PROGRAM = 8'hC5;
   localparam logic [7:0]  ST_CHAN_LO = 8'h80;
   localparam logic [7:0]  ST_CHAN_HI = 8'hEF;
   localparam logic [7:0]  META_END   = 8'h2F;
   localparam logic [7:0]  VLQ_MORE   = 8'h80;
   localparam logic [27:0] DELTA_MAX  = '1;

   localparam logic [2:0] INJECTED_ERRORS [5] = '{ERR_LONG_DELTA, ERR_NO_RUNNING,
      ERR_BAD_STATUS, ERR_BAD_LENGTH, ERR_SYSEX_LARGE};

   typedef struct packed {
      logic [7:0] value;
      logic       first;
      logic       last;
   } track_byte_type;

   logic clock;
   logic reset;

   smftep_req_if req_if();
   smftep_rsp_if rsp_if();

   smf_track_event_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // stimulus and expectations
   track_byte_type pending_bytes[$];
   logic [7:0]   track_buf[$];
   rsp_item_type expected_results[$];
   rsp_item_type step_out[$];
   int           items_sent;
   int           mismatches;
   int           cycle_count;

   // handshake bookkeeping between the rising and falling edge blocks
   bit req_taken, rsp_taken;
   bit req_burst, rsp_burst;
   int req_gap, rsp_wait;

   // parser model state
   phase_type   ph;
   logic [27:0] vlq_acc;
   logic [2:0]  vlq_len;
   logic [31:0] tick;
   logic [7:0]  run_status;
   logic [7:0]  cur_status;
   logic [1:0]  data_left;
   logic [7:0]  meta_kind;
   logic [27:0] remain;
   int          sysex_seen;
   logic [23:0] tempo_acc;
   bit          tempo_ok;
   bit          halted;

   function automatic void clear_parser();
      ph         = PH_DELTA;
      vlq_acc    = '0;
      vlq_len    = '0;
      tick       = '0;
      run_status = '0;
      cur_status = '0;
      data_left  = '0;
      meta_kind  = '0;
      remain     = '0;
      sysex_seen = 0;
      tempo_acc  = '0;
      tempo_ok   = 1'b0;
      halted     = 1'b0;
   endfunction

   function automatic logic [1:0] chan_data_len(input logic [7:0] status);
      return (status[7:4] == HI_PROGRAM || status[7:4] == HI_PRESSURE) ? 2'd1 : 2'd2;
   endfunction

   function automatic void add_result(input logic [1:0] kind, input logic [7:0] value,
                                      input logic first, input logic [23:0] tempo,
                                      input logic [2:0] code);
      rsp_item_type r;
      r = '0;
      r.kind = kind;
      r.byte_value = value;
      r.event_tick = (kind == KIND_ERROR) ? 32'd0 : tick;
      r.first_of_event = first;
      r.quarter_usec = tempo;
      r.error_code = code;
      step_out.push_back(r);
   endfunction

   // an error replaces whatever this byte produced and halts the track
   function automatic void raise_error(input logic [2:0] code);
      halted = 1'b1;
      step_out.delete();
      add_result(KIND_ERROR, 8'd0, 1'b0, 24'd0, code);
   endfunction

   // 0: more bytes, 1: complete, -1: too long
   function automatic int take_vlq(input logic [7:0] b);
      vlq_acc = {vlq_acc[20:0], b[6:0]};
      vlq_len = vlq_len + 3'd1;
      if (b[7]) begin
         return (vlq_len >= 3'd4) ? -1 : 0;
      end
      return 1;
   endfunction

   function automatic void parse_body(input logic [7:0] b);
      int          v;
      logic [32:0] sum;
      logic [27:0] slen;
      bit          fin;
      case (ph)
         PH_DELTA: begin
            v = take_vlq(b);
            if (v < 0) begin
               raise_error(ERR_LONG_DELTA);
            end else if (v > 0) begin
               sum = {1'b0, tick} + 33'(vlq_acc);
               tick = sum[32] ? '1 : sum[31:0];
               vlq_acc = '0;
               vlq_len = '0;
               ph = PH_STATUS;
            end
         end
         PH_STATUS: begin
            if (!b[7]) begin
               if (run_status == '0) begin
                  raise_error(ERR_NO_RUNNING);
               end else begin
                  cur_status = run_status;
                  add_result(KIND_EVENT, run_status, 1'b1, 24'd0, 3'd0);
                  add_result(KIND_EVENT, b, 1'b0, 24'd0, 3'd0);
                  data_left = chan_data_len(run_status) - 2'd1;
                  ph = (data_left != '0) ? PH_CHAN : PH_DELTA;
               end
            end else if (b < ST_SYSEX) begin
               run_status = b;
               cur_status = b;
               data_left = chan_data_len(b);
               ph = PH_CHAN;
               add_result(KIND_EVENT, b, 1'b1, 24'd0, 3'd0);
            end else if (b == ST_META) begin
               ph = PH_META_TYPE;
            end else if (b == ST_SYSEX || b == ST_ESCAPE) begin
               cur_status = b;
               ph = PH_SYX_LEN;
            end else begin
               raise_error(ERR_BAD_STATUS);
            end
         end
         PH_CHAN: begin
            add_result(KIND_EVENT, b, 1'b0, 24'd0, 3'd0);
            data_left = data_left - 2'd1;
            if (data_left == '0) ph = PH_DELTA;
         end
         PH_META_TYPE: begin
            meta_kind = b;
            ph = PH_META_LEN;
         end
         PH_META_LEN: begin
            v = take_vlq(b);
            if (v < 0) begin
               raise_error(ERR_BAD_LENGTH);
            end else if (v > 0) begin
               remain = vlq_acc;
               tempo_ok = (meta_kind == META_TEMPO && vlq_acc == 28'(TEMPO_LEN));
               tempo_acc = '0;
               vlq_acc = '0;
               vlq_len = '0;
               ph = (remain != '0) ? PH_META_DATA : PH_DELTA;
            end
         end
         PH_META_DATA: begin
            if (tempo_ok) tempo_acc = {tempo_acc[15:0], b};
            remain = remain - 28'd1;
            if (remain == '0) begin
               ph = PH_DELTA;
               if (tempo_ok) add_result(KIND_TEMPO, 8'd0, 1'b0, tempo_acc, 3'd0);
            end
         end
         PH_SYX_LEN: begin
            v = take_vlq(b);
            if (v < 0) begin
               raise_error(ERR_BAD_LENGTH);
            end else if (v > 0) begin
               slen = vlq_acc;
               vlq_acc = '0;
               vlq_len = '0;
               remain = slen;
               if (cur_status == ST_SYSEX) begin
                  if (int'(slen) > SYSEX_LIMIT - 1) begin
                     raise_error(ERR_SYSEX_LARGE);
                  end else begin
                     sysex_seen = 1;
                     add_result(KIND_EVENT, ST_SYSEX, 1'b1, 24'd0, 3'd0);
                     if (slen == '0) begin
                        add_result(KIND_EVENT, ST_ESCAPE, 1'b0, 24'd0, 3'd0);
                        ph = PH_DELTA;
                     end else begin
                        ph = PH_SYX_DATA;
                     end
                  end
               end else if (int'(slen) > SYSEX_LIMIT) begin
                  raise_error(ERR_SYSEX_LARGE);
               end else begin
                  sysex_seen = 0;
                  ph = (slen != '0) ? PH_SYX_DATA : PH_DELTA;
               end
            end
         end
         PH_SYX_DATA: begin
            remain = remain - 28'd1;
            fin = (remain == '0);
            if (fin && cur_status == ST_SYSEX && b != ST_ESCAPE &&
                sysex_seen + 1 >= SYSEX_LIMIT) begin
               raise_error(ERR_SYSEX_LARGE);
            end else begin
               add_result(KIND_EVENT, b, sysex_seen == 0, 24'd0, 3'd0);
               sysex_seen++;
               if (fin) begin
                  if (cur_status == ST_SYSEX && b != ST_ESCAPE) begin
                     add_result(KIND_EVENT, ST_ESCAPE, 1'b0, 24'd0, 3'd0);
                  end
                  ph = PH_DELTA;
               end
            end
         end
         default: ph = PH_DELTA;
      endcase
   endfunction

   function automatic void parse_track_byte(input track_byte_type it);
      step_out.delete();
      if (it.first) clear_parser();
      if (!halted) begin
         parse_body(it.value);
         if (it.last && !halted && (ph != PH_DELTA || vlq_len != '0)) begin
            raise_error(ERR_TRUNCATED);
         end
         if (step_out.size() > 0) step_out[step_out.size() - 1].is_last = 1'b1;
         foreach (step_out[i]) expected_results.push_back(step_out[i]);
      end
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         end
      end
   endfunction

   function automatic int draw_wait(inout bit burst);
      if ($urandom_range(0, 39) == 0) burst = !burst;
      return burst ? 0 : $urandom_range(0, 10);
   endfunction

   // ---- track construction ----

   function automatic logic [27:0] rand_delta();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 28'($urandom_range(0, 127));
      if (r < 85) return 28'($urandom_range(0, 16383));
      if (r < 95) return 28'($urandom_range(0, 2097151));
      return 28'($urandom_range(0, int'(DELTA_MAX)));
   endfunction

   function automatic logic [7:0] rand_data();
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, 127));
   endfunction

   // pad adds redundant leading continuation bytes
   function automatic void put_vlq(input logic [27:0] value, input int pad);
      int groups;
      groups = 1;
      while (groups < 4 && (value >> (7 * groups)) != 0) groups++;
      for (int i = 0; i < pad && groups + i < 4; i++) track_buf.push_back(VLQ_MORE);
      for (int i = groups - 1; i >= 0; i--) track_buf.push_back({i != 0, value[7 * i +: 7]});
   endfunction

   function automatic void put_channel(input logic [7:0] status, input bit with_status);
      int count;
      count = int'(chan_data_len(status));
      if (with_status) track_buf.push_back(status);
      for (int i = 0; i < count; i++) begin
         // under running status the first data byte must look like data
         if (i == 0 && !with_status) begin
            track_buf.push_back(($urandom_range(0, 4) == 0) ? 8'h00 :
                                8'($urandom_range(0, 127)));
         end else begin
            track_buf.push_back(rand_data());
         end
      end
   endfunction

   function automatic void put_meta(input logic [7:0] kind, input int len);
      track_buf.push_back(ST_META);
      track_buf.push_back(kind);
      put_vlq(28'(len), ($urandom_range(0, 9) == 0) ? 1 : 0);
      for (int i = 0; i < len; i++) track_buf.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void put_sysex(input logic [7:0] status, input int len, input bit close);
      logic [7:0] tail;
      track_buf.push_back(status);
      put_vlq(28'(len), ($urandom_range(0, 9) == 0) ? 1 : 0);
      for (int i = 0; i < len - 1; i++) track_buf.push_back(8'($urandom_range(0, 255)));
      if (len > 0) begin
         tail = 8'($urandom_range(0, 255));
         if (tail == ST_ESCAPE) tail = ST_ESCAPE - 8'd1;
         track_buf.push_back(close ? ST_ESCAPE : tail);
      end
   endfunction

   function automatic void put_error(input logic [2:0] code);
      logic [7:0] v;
      if (code != ERR_LONG_DELTA) put_vlq(rand_delta(), 0);
      case (code)
         ERR_LONG_DELTA: begin
            for (int i = 0; i < 4; i++) track_buf.push_back(VLQ_MORE | 8'($urandom_range(0, 127)));
         end
         ERR_NO_RUNNING: track_buf.push_back(8'($urandom_range(0, 127)));
         ERR_BAD_STATUS: begin
            v = 8'($urandom_range(int'(ST_SYSEX) + 1, int'(ST_META) - 1));
            if (v == ST_ESCAPE) v = ST_ESCAPE + 8'd1;
            track_buf.push_back(v);
         end
         ERR_BAD_LENGTH: begin
            if ($urandom_range(0, 1) == 0) begin
               track_buf.push_back(ST_META);
               track_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
               track_buf.push_back(($urandom_range(0, 1) == 0) ? ST_SYSEX : ST_ESCAPE);
            end
            for (int i = 0; i < 4; i++) track_buf.push_back(VLQ_MORE | 8'($urandom_range(0, 127)));
         end
         default: begin
            if ($urandom_range(0, 1) == 0) begin
               track_buf.push_back(ST_SYSEX);
               put_vlq(($urandom_range(0, 3) == 0) ?
                       28'($urandom_range(SYSEX_LIMIT, int'(DELTA_MAX))) :
                       28'($urandom_range(SYSEX_LIMIT, SYSEX_LIMIT + 64)), 0);
            end else begin
               track_buf.push_back(ST_ESCAPE);
               put_vlq(($urandom_range(0, 3) == 0) ?
                       28'($urandom_range(SYSEX_LIMIT + 1, int'(DELTA_MAX))) :
                       28'($urandom_range(SYSEX_LIMIT + 1, SYSEX_LIMIT + 64)), 0);
            end
         end
      endcase
   endfunction

   function automatic void send_track(input bit end_flag, input bit counted);
      foreach (track_buf[i]) begin
         pending_bytes.push_back('{value: track_buf[i], first: i == 0,
                                   last: end_flag && i == track_buf.size() - 1});
      end
      if (counted) items_sent += track_buf.size();
      track_buf.delete();
   endfunction

   // bytes after an error inside the same track; the block ignores them
   function automatic void add_junk(input int n);
      for (int i = 0; i < n; i++) begin
         pending_bytes.push_back('{value: 8'($urandom_range(0, 255)), first: 1'b0,
                                   last: $urandom_range(0, 3) == 0});
      end
   endfunction

   function automatic void end_of_track();
      put_vlq(28'd0, 0);
      track_buf.push_back(ST_META);
      track_buf.push_back(META_END);
      track_buf.push_back(8'h00);
   endfunction

   function automatic void random_track();
      int         events, err_at, pick, cut;
      bit         have_run, errored;
      logic [7:0] status;
      logic [2:0] code;
      events = $urandom_range(1, 10);
      err_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, events - 1) : -1;
      have_run = 1'b0;
      errored = 1'b0;
      status = ST_CHAN_LO;
      for (int e = 0; e < events && !errored; e++) begin
         if (e == err_at) begin
            code = INJECTED_ERRORS[$urandom_range(0, 4)];
            if (code == ERR_NO_RUNNING && have_run) code = ERR_BAD_STATUS;
            put_error(code);
            errored = 1'b1;
         end else begin
            put_vlq(rand_delta(), ($urandom_range(0, 9) == 0) ? 1 : 0);
            pick = $urandom_range(0, 99);
            if (pick < 35 || (pick < 55 && !have_run)) begin
               status = 8'($urandom_range(int'(ST_CHAN_LO), int'(ST_CHAN_HI)));
               put_channel(status, 1'b1);
               have_run = 1'b1;
            end else if (pick < 55) begin
               put_channel(status, 1'b0);
            end else if (pick < 65) begin
               put_meta(8'($urandom_range(0, 255)), $urandom_range(0, 5));
            end else if (pick < 73) begin
               put_meta(META_TEMPO, TEMPO_LEN);
            end else if (pick < 77) begin
               put_meta(META_TEMPO, ($urandom_range(0, 1) == 0) ? TEMPO_LEN - 1 :
                        $urandom_range(TEMPO_LEN + 1, TEMPO_LEN + 3));
            end else if (pick < 90) begin
               put_sysex(ST_SYSEX, $urandom_range(0, 8), $urandom_range(0, 1));
            end else begin
               put_sysex(ST_ESCAPE, $urandom_range(0, 6), 1'b0);
            end
         end
      end
      if (errored) begin
         send_track($urandom_range(0, 1), 1'b1);
         add_junk($urandom_range(0, 3));
      end else begin
         if ($urandom_range(0, 4) != 0) end_of_track();
         // cut the track short, with or without an end flag
         if ($urandom_range(0, 7) == 0 && track_buf.size() > 1) begin
            cut = $urandom_range(1, track_buf.size() - 1);
            while (track_buf.size() > cut) void'(track_buf.pop_back());
            send_track($urandom_range(0, 1), 1'b1);
         end else begin
            send_track(1'b1, 1'b1);
         end
      end
   endfunction

   // enough maximal deltas to pin the tick at its ceiling
   function automatic void saturation_track();
      for (int e = 0; e < SAT_EVENTS; e++) begin
         put_vlq(DELTA_MAX, 0);
         put_channel(8'($urandom_range(int'(ST_CHAN_LO), int'(ST_CHAN_HI))), 1'b1);
      end
      put_vlq(rand_delta(), 0);
      put_meta(META_TEMPO, TEMPO_LEN);
      send_track(1'b1, 1'b1);
   endfunction

   function automatic void noise_track();
      int n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         pending_bytes.push_back('{value: 8'($urandom_range(0, 255)),
                                   first: $urandom_range(0, 3) == 0,
                                   last: $urandom_range(0, 3) == 0});
      end
      items_sent += n;
   endfunction

   function automatic void big_sysex(input logic [7:0] status, input int len, input bit close);
      put_vlq(28'd0, 0);
      put_sysex(status, len, close);
      send_track(1'b1, 1'b0);
   endfunction

   // ---- result check and prediction at the rising edge ----
   always @(posedge clock) begin
      rsp_item_type want;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("smf_track_event_parser_test failed");
         $finish;
      end else if (reset) begin
         clear_parser();
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_taken = 1'b1;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("%0t: result with none pending, expected nothing, got kind %0h byte %0h",
                           $time, rsp_if.kind, rsp_if.byte_value);
               end
            end else begin
               want = expected_results.pop_front();
               compare_field("kind", 32'(want.kind), 32'(rsp_if.kind));
               compare_field("byte_value", 32'(want.byte_value), 32'(rsp_if.byte_value));
               compare_field("event_tick", want.event_tick, rsp_if.event_tick);
               compare_field("first_of_event", 32'(want.first_of_event),
                             32'(rsp_if.first_of_event));
               compare_field("quarter_usec", 32'(want.quarter_usec),
                             32'(rsp_if.quarter_usec));
               compare_field("error_code", 32'(want.error_code), 32'(rsp_if.error_code));
               compare_field("is_last", 32'(want.is_last), 32'(rsp_if.is_last));
            end
         end
         if (req_if.valid && req_if.ready) begin
            req_taken = 1'b1;
            parse_track_byte('{value: req_if.data_byte, first: req_if.first_of_track,
                               last: req_if.last_of_track});
         end
      end
   end

   // ---- byte driver ----
   always @(negedge clock) begin
      bit             hold;
      track_byte_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         hold = req_if.valid && !req_taken;
         req_taken = 1'b0;
         if (!hold) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_bytes.size() > 0) begin
               nxt = pending_bytes.pop_front();
               req_if.data_byte      <= nxt.value;
               req_if.first_of_track <= nxt.first;
               req_if.last_of_track  <= nxt.last;
               hold = 1'b1;
               req_gap = draw_wait(req_burst);
            end
         end
         req_if.valid <= hold;
      end
   end

   // ---- result back-pressure ----
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rsp_wait = draw_wait(rsp_burst);
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      int r;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data_byte = 8'd0;
      req_if.first_of_track = 1'b0;
      req_if.last_of_track = 1'b0;
      rsp_if.ready = 1'b0;
      clear_parser();

      // well-formed track: running status with a zero data byte, data byte with
      // bit 7 set, tempo, escape, empty SysEx that gets its closing byte
      put_vlq(28'd0, 0);
      track_buf.push_back(ST_NOTE_ON);
      track_buf.push_back(8'h3C);
      track_buf.push_back(8'h7F);
      put_vlq(28'd0, 0);
      track_buf.push_back(8'h00);
      track_buf.push_back(8'h40);
      put_vlq(28'd128, 0);
      track_buf.push_back(ST_PROGRAM);
      track_buf.push_back(8'h80);
      put_vlq(28'd0, 0);
      track_buf.push_back(ST_META);
      track_buf.push_back(META_TEMPO);
      put_vlq(28'(TEMPO_LEN), 0);
      track_buf.push_back(8'h07);
      track_buf.push_back(8'hA1);
      track_buf.push_back(8'h20);
      put_vlq(28'd0, 0);
      track_buf.push_back(ST_ESCAPE);
      put_vlq(28'd1, 0);
      track_buf.push_back(8'hFF);
      put_vlq(28'd0, 0);
      track_buf.push_back(ST_SYSEX);
      put_vlq(28'd0, 0);
      send_track(1'b1, 1'b1);

      // each error at the start of a track, then a byte that must be ignored
      foreach (INJECTED_ERRORS[i]) begin
         put_error(INJECTED_ERRORS[i]);
         send_track(1'b0, 1'b1);
         add_junk(1);
      end

      // track ending inside a message, and inside the status position
      put_vlq(28'd0, 0);
      track_buf.push_back(ST_NOTE_ON);
      track_buf.push_back(8'h3C);
      send_track(1'b1, 1'b1);
      put_vlq(28'd0, 0);
      send_track(1'b1, 1'b1);

      // SysEx at the size limit
      big_sysex(ST_SYSEX, SYSEX_LIMIT - 2, 1'b0);
      big_sysex(ST_SYSEX, SYSEX_LIMIT - 1, 1'b0);
      big_sysex(ST_SYSEX, SYSEX_LIMIT - 1, 1'b1);
      big_sysex(ST_ESCAPE, SYSEX_LIMIT, 1'b0);
      saturation_track();

      while (items_sent < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 3) saturation_track();
         else if (r < 10) noise_track();
         else random_track();
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_if.valid || expected_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("smf_track_event_parser_test passed");
      end else begin
         $display("smf_track_event_parser_test failed");
      end
      $finish;
   end

endmodule

@@ smf_track_event_parser.f @@
rtl/smftep_pkg.sv
rtl/smftep_if.sv
rtl/smftep_parser.sv
rtl/smftep_rsp_queue.sv
rtl/smf_track_event_parser.sv
bench/smf_track_event_parser_test.sv
